/* hw/rtl/iou_pkg.sv */
// ----------------------------------------------------------------------------
// iou_pkg
// Shared constants and types for the box intersection-over-union unit.
// ----------------------------------------------------------------------------
package iou_pkg;

  // integer bits in front of the fraction of the ratio
  localparam int unsigned RatioIntBits = 1;

  // control that travels with each beat through the divider cells
  typedef struct packed {
    logic valid;
  } iou_ctrl_t;

endpackage

/* hw/rtl/iou_geom.sv */
// ----------------------------------------------------------------------------
// iou_geom
// Overlap extents, the three areas and the union, five register stages deep.
// ----------------------------------------------------------------------------
module iou_geom #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [COORD_BITS-1:0]   first_left_i,
  input  logic [COORD_BITS-1:0]   first_top_i,
  input  logic [COORD_BITS-1:0]   first_width_i,
  input  logic [COORD_BITS-1:0]   first_height_i,
  input  logic [COORD_BITS-1:0]   second_left_i,
  input  logic [COORD_BITS-1:0]   second_top_i,
  input  logic [COORD_BITS-1:0]   second_width_i,
  input  logic [COORD_BITS-1:0]   second_height_i,
  output iou_pkg::iou_ctrl_t      ctrl_o,
  output logic [2*COORD_BITS:0]   num_o,
  output logic [2*COORD_BITS:0]   den_o
);
  import iou_pkg::*;

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned AW = 2 * COORD_BITS;

  // stage 1: edges
  logic                  s1_vld_q;
  logic [EW-1:0]         s1_lx_q, s1_rx_q, s1_ty_q, s1_by_q;
  logic [COORD_BITS-1:0] s1_aw_q, s1_ah_q, s1_bw_q, s1_bh_q;
  logic [EW-1:0]         ax, bx, ay, by, ar, br, ab, bb;

  // stage 2: overlap size
  logic                  s2_vld_q, s2_ovl_q;
  logic [COORD_BITS-1:0] s2_ow_q, s2_oh_q;
  logic [COORD_BITS-1:0] s2_aw_q, s2_ah_q, s2_bw_q, s2_bh_q;
  logic [EW-1:0]         ow_full, oh_full;

  // stage 3: areas
  logic                  s3_vld_q, s3_ovl_q;
  logic [AW-1:0]         s3_int_q, s3_a1_q, s3_a2_q;

  // stage 4: area sum
  logic                  s4_vld_q, s4_ovl_q;
  logic [AW-1:0]         s4_int_q;
  logic [AW:0]           s4_sum_q;

  // stage 5: union and divider operands
  logic                  s5_vld_q;
  logic [AW:0]           s5_num_q, s5_den_q;

  always_comb begin
    ax = {1'b0, first_left_i};
    bx = {1'b0, second_left_i};
    ay = {1'b0, first_top_i};
    by = {1'b0, second_top_i};
    ar = ax + {1'b0, first_width_i};
    br = bx + {1'b0, second_width_i};
    ab = ay + {1'b0, first_height_i};
    bb = by + {1'b0, second_height_i};
    ow_full = s1_rx_q - s1_lx_q;
    oh_full = s1_by_q - s1_ty_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_lx_q  <= (ax > bx) ? ax : bx;
    s1_rx_q  <= (ar < br) ? ar : br;
    s1_ty_q  <= (ay > by) ? ay : by;
    s1_by_q  <= (ab < bb) ? ab : bb;
    s1_aw_q  <= first_width_i;
    s1_ah_q  <= first_height_i;
    s1_bw_q  <= second_width_i;
    s1_bh_q  <= second_height_i;

    s2_ovl_q <= (s1_lx_q < s1_rx_q) && (s1_ty_q < s1_by_q);
    s2_ow_q  <= ow_full[COORD_BITS-1:0];
    s2_oh_q  <= oh_full[COORD_BITS-1:0];
    s2_aw_q  <= s1_aw_q;
    s2_ah_q  <= s1_ah_q;
    s2_bw_q  <= s1_bw_q;
    s2_bh_q  <= s1_bh_q;

    s3_ovl_q <= s2_ovl_q;
    s3_int_q <= AW'(s2_ow_q * s2_oh_q);
    s3_a1_q  <= AW'(s2_aw_q * s2_ah_q);
    s3_a2_q  <= AW'(s2_bw_q * s2_bh_q);

    s4_ovl_q <= s3_ovl_q;
    s4_int_q <= s3_int_q;
    s4_sum_q <= {1'b0, s3_a1_q} + {1'b0, s3_a2_q};

    // no overlap: 0 / 1 gives a zero ratio
    s5_num_q <= s4_ovl_q ? {1'b0, s4_int_q} : '0;
    s5_den_q <= s4_ovl_q ? (s4_sum_q - {1'b0, s4_int_q}) : (AW + 1)'(1);
  end

  assign ctrl_o.valid = s5_vld_q;
  assign num_o        = s5_num_q;
  assign den_o        = s5_den_q;

endmodule

/* hw/rtl/iou_div_cell.sv */
// ----------------------------------------------------------------------------
// iou_div_cell
// One restoring division step: shift (skipped in the first cell), compare, subtract, append quotient bit.
// ----------------------------------------------------------------------------
module iou_div_cell #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16,
  parameter bit          FIRST         = 1'b0
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  iou_pkg::iou_ctrl_t                                ctrl_i,
  input  logic [2*COORD_BITS+1:0]                           rem_i,
  input  logic [2*COORD_BITS:0]                             den_i,
  input  logic [FRACTION_BITS+iou_pkg::RatioIntBits-1:0]    quo_i,
  output iou_pkg::iou_ctrl_t                                ctrl_o,
  output logic [2*COORD_BITS+1:0]                           rem_o,
  output logic [2*COORD_BITS:0]                             den_o,
  output logic [FRACTION_BITS+iou_pkg::RatioIntBits-1:0]    quo_o
);
  import iou_pkg::*;

  localparam int unsigned RW = 2 * COORD_BITS + 2;
  localparam int unsigned QW = FRACTION_BITS + RatioIntBits;

  iou_ctrl_t     ctrl_q;
  logic [RW-1:0] rem_q, trial, rem_d;
  logic [RW-2:0] den_q;
  logic [QW-1:0] quo_q;
  logic          ge;

  always_comb begin
    trial = FIRST ? rem_i : {rem_i[RW-2:0], 1'b0};
    ge    = trial >= {1'b0, den_i};
    rem_d = ge ? (trial - {1'b0, den_i}) : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_i;
    quo_q <= {quo_i[QW-2:0], ge};
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign den_o  = den_q;
  assign quo_o  = quo_q;

endmodule

/* hw/rtl/box_intersection_over_union_unit.sv */
// ----------------------------------------------------------------------------
// box_intersection_over_union_unit
// Intersection over union of two boxes as an unsigned Q1.FRACTION_BITS ratio.
// ----------------------------------------------------------------------------
// from start to done a beat passes through the registered stages:
//   five geometry/area stages, then one divider cell per quotient bit
// throughput: one beat per cycle, busy_o is never raised
// reset clears only the valid pipeline; no clearing pass, ready at once
// results cannot be stalled and appear on done_o for one cycle
module box_intersection_over_union_unit #(
  parameter int unsigned COORD_BITS    = 16,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  output logic                                             busy_o,
  input  logic [COORD_BITS-1:0]                            first_left_i,
  input  logic [COORD_BITS-1:0]                            first_top_i,
  input  logic [COORD_BITS-1:0]                            first_width_i,
  input  logic [COORD_BITS-1:0]                            first_height_i,
  input  logic [COORD_BITS-1:0]                            second_left_i,
  input  logic [COORD_BITS-1:0]                            second_top_i,
  input  logic [COORD_BITS-1:0]                            second_width_i,
  input  logic [COORD_BITS-1:0]                            second_height_i,
  output logic                                             done_o,
  output logic [FRACTION_BITS+iou_pkg::RatioIntBits-1:0]   overlap_ratio_o
);
  import iou_pkg::*;

  localparam int unsigned RW      = 2 * COORD_BITS + 2;
  localparam int unsigned QW      = FRACTION_BITS + RatioIntBits;
  localparam int unsigned NCELL   = FRACTION_BITS + 1;
  localparam int unsigned Latency = NCELL + 5;

  iou_ctrl_t     ctrl   [NCELL+1];
  logic [RW-1:0] rem    [NCELL+1];
  logic [RW-2:0] den    [NCELL+1];
  logic [QW-1:0] quo    [NCELL+1];
  logic [RW-2:0] num;

  assign busy_o = 1'b0;

  iou_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start_i),
    .first_left_i    (first_left_i),
    .first_top_i     (first_top_i),
    .first_width_i   (first_width_i),
    .first_height_i  (first_height_i),
    .second_left_i   (second_left_i),
    .second_top_i    (second_top_i),
    .second_width_i  (second_width_i),
    .second_height_i (second_height_i),
    .ctrl_o          (ctrl[0]),
    .num_o           (num),
    .den_o           (den[0])
  );

  assign rem[0] = {1'b0, num};
  assign quo[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    iou_div_cell #(
      .COORD_BITS    (COORD_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .FIRST         (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[k]),
      .rem_i  (rem[k]),
      .den_i  (den[k]),
      .quo_i  (quo[k]),
      .ctrl_o (ctrl[k+1]),
      .rem_o  (rem[k+1]),
      .den_o  (den[k+1]),
      .quo_o  (quo[k+1])
    );
  end

  assign done_o          = ctrl[NCELL].valid;
  assign overlap_ratio_o = quo[NCELL];

  // every result beat traces back to a start beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result beat without matching start");

  // ratio never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (overlap_ratio_o <= (QW'(1) << FRACTION_BITS)))
    else $error("overlap ratio above one");

  // remainder stays below the divisor at the end of the chain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rem[NCELL] < {1'b0, den[NCELL]}))
    else $error("divider remainder out of range");

endmodule
